// ===== rtl/atrw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package atrw_pkg;

  localparam int FIELD_W = 32;
  localparam int CFG_W   = 8;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd14;

  typedef struct packed {
    logic busy;
    logic done;
  } atrw_unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/atrw_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atrw_mul import atrw_pkg::*; #(
  parameter int A_W = 32,
  parameter int B_W = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [A_W-1:0]       a_in,
  input  wire logic [B_W-1:0]       b_in,
  output atrw_unit_stat_t           stat,
  output logic      [A_W+B_W-1:0]   prod
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a;
  logic [B_W-1:0]   b;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (go) begin
        a    <= a_in;
        b    <= b_in;
        prod <= '0;
        cnt  <= CNT_W'(B_W);
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        // one multiplier bit per cycle, MSB first
        prod <= {prod[P_W-2:0], 1'b0} + (b[B_W-1] ? P_W'(a) : '0);
        b    <= {b[B_W-2:0], 1'b0};
        cnt  <= cnt - CNT_W'(1);
        busy <= (cnt != CNT_W'(1));
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atrw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atrw_div import atrw_pkg::*; #(
  parameter int N_W = 40,
  parameter int D_W = 8,
  parameter int Q_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [N_W-1:0]   num,
  input  wire logic [D_W-1:0]   den,
  output atrw_unit_stat_t       stat,
  output logic      [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   dvd;
  logic [D_W-1:0]   dsr;
  logic [D_W-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     rem_sh;
  logic             ge;

  assign stat   = '{busy: busy, done: done};
  assign rem_sh = {rem, dvd[N_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (go) begin
        dvd  <= num;
        dsr  <= den;
        rem  <= '0;
        quot <= '0;
        cnt  <= CNT_W'(N_W);
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        // restoring step: one quotient bit per cycle
        rem  <= ge ? D_W'(rem_sh - {1'b0, dsr}) : rem_sh[D_W-1:0];
        dvd  <= {dvd[N_W-2:0], 1'b0};
        quot <= {quot[Q_W-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
        busy <= (cnt != CNT_W'(1));
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/average_true_range_wilder_core.sv =====
// Wilder average true range over a stream of price bars. One transaction on
// the slave side carries one bar (high, low, close in unsigned Q16.16 and a
// series start flag); the block answers with exactly one transaction on the
// master side carrying the current ATR, the bar's true range and a flag that
// is set once smoothing_period bars of the series have arrived. Until then
// the ATR output is the truncated mean of the ranges seen so far. Bars are
// processed one at a time: after the true range is formed in the S_DIFF and
// S_MAX states, the running sum (or, once valid, atr*(period-1)+tr formed by
// a bit-serial multiplier) is divided by a restoring divider that retires
// one quotient bit per cycle. The block is ready for the next bar in the
// same cycle as the result appears. A finished result waits in the output
// register while the next bar is taken in. The period register is written
// only while no bar is in flight.
`timescale 1ns / 1ps
`default_nettype none

module average_true_range_wilder_core import atrw_pkg::*; #(
  parameter int PRICE_WIDTH = 32,
  parameter int PERIOD_MAX  = 255
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // bar_high, bar_low, bar_close
  input  wire logic         s_axis_tuser,  // series_start
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [63:0]  m_axis_tdata,  // atr_value, bar_true_range
  output logic              m_axis_tuser,  // atr_valid
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data       // smoothing_period
);

  localparam int PW    = PRICE_WIDTH;
  localparam int CW    = $clog2(PERIOD_MAX + 1);
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
  localparam int AW    = PW + CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MAX,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t          state;
  logic [CFG_W-1:0] period_reg;
  logic [PW-1:0]   bar_high;
  logic [PW-1:0]   bar_low;
  logic [PW-1:0]   bar_close;
  logic            start;
  logic [PW-1:0]   prior_close;
  logic [PW-1:0]   d_hl;
  logic [PW-1:0]   d_a;
  logic [PW-1:0]   d_b;
  logic [PW-1:0]   tr;
  logic [CW-1:0]   bars_seen;
  logic [AW-1:0]   acc;
  logic            smoothing;
  logic            mul_go;
  logic            div_go;
  logic [AW-1:0]   num;
  logic [CW-1:0]   den;

  logic [CMP_W-1:0] period_wide;
  logic [CW-1:0]    period_eff;
  logic [PW-1:0]    tr_cand;
  logic [CW-1:0]    seen_eff;
  logic [CW-1:0]    seen_new;
  logic [AW-1:0]    acc_base;
  logic             smooth_eff;

  atrw_unit_stat_t  mul_stat;
  atrw_unit_stat_t  div_stat;
  logic [AW-1:0]    mul_prod;
  logic [PW-1:0]    div_quot;

  function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] x, input logic [PW-1:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  assign cfg_ready     = (state == S_IDLE) && !mul_stat.busy && !div_stat.busy;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    period_wide = (period_reg == '0) ? CMP_W'(1) : CMP_W'(period_reg);
    if (period_wide > CMP_W'(PERIOD_MAX)) begin
      period_wide = CMP_W'(PERIOD_MAX);
    end
    period_eff = CW'(period_wide);
  end

  always_comb begin
    tr_cand = d_hl;
    if (!start) begin
      if (d_a > tr_cand) tr_cand = d_a;
      if (d_b > tr_cand) tr_cand = d_b;
    end
    seen_eff   = start ? '0 : bars_seen;
    seen_new   = (seen_eff < CW'(PERIOD_MAX)) ? seen_eff + CW'(1) : seen_eff;
    acc_base   = start ? '0 : acc;
    smooth_eff = start ? 1'b0 : smoothing;
  end

  atrw_mul #(
    .A_W (PW),
    .B_W (CW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a_in (acc[PW-1:0]),
    .b_in (period_eff - CW'(1)),
    .stat (mul_stat),
    .prod (mul_prod)
  );

  atrw_div #(
    .N_W (AW),
    .D_W (CW),
    .Q_W (PW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (num),
    .den  (den),
    .stat (div_stat),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      period_reg     <= PERIOD_RESET;
      prior_close    <= '0;
      bars_seen      <= '0;
      acc            <= '0;
      smoothing      <= 1'b0;
      mul_go         <= 1'b0;
      div_go         <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      mul_go <= (state == S_MAX) && smooth_eff;
      div_go <= ((state == S_MAX) && !smooth_eff) || ((state == S_MUL) && mul_stat.done);
      if (cfg_valid && cfg_ready) begin
        period_reg <= cfg_data;
      end
      if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            bar_high  <= PW'(s_axis_tdata[31:0]);
            bar_low   <= PW'(s_axis_tdata[63:32]);
            bar_close <= PW'(s_axis_tdata[95:64]);
            start     <= s_axis_tuser || (bars_seen == '0);
            state     <= S_DIFF;
          end
        end
        S_DIFF: begin
          d_hl        <= (bar_high >= bar_low) ? bar_high - bar_low : '0;
          d_a         <= abs_diff(bar_high, prior_close);
          d_b         <= abs_diff(bar_low, prior_close);
          prior_close <= bar_close;
          state       <= S_MAX;
        end
        S_MAX: begin
          tr        <= tr_cand;
          bars_seen <= seen_new;
          smoothing <= smooth_eff;
          if (smooth_eff) begin
            state <= S_MUL;
          end else begin
            acc   <= acc_base + AW'(tr_cand);
            num   <= acc_base + AW'(tr_cand);
            den   <= seen_new;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            num   <= mul_prod + AW'(tr);
            den   <= period_eff;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (smoothing || (bars_seen >= period_eff)) begin
              smoothing <= 1'b1;
              acc       <= AW'(div_quot);
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {FIELD_W'(tr), FIELD_W'(div_quot)};
            m_axis_tuser <= smoothing;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atrw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atrw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("reset did not clear the output and reopen the input");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while a bar is in flight");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised while the block was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind average_true_range_wilder_core atrw_checker u_atrw_checker (.*);

`default_nettype wire
